>>> hw/rtl/pes_hp_pkg.sv
// Shared types and constants for the PES header parser.
// No dependencies; imported by pes_hp_core and pes_header_parser_top.
package pes_hp_pkg;

  localparam int unsigned TS_W  = 33;  // PTS / DTS width
  localparam int unsigned POS_W = 17;  // saturating byte position

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_START  = 3'd1,
    ERR_NO_PTS = 3'd2,
    ERR_PREFIX = 3'd3,
    ERR_MARKER = 3'd4,
    ERR_SHORT  = 3'd5
  } err_e;

  // One result item, as produced for each accepted byte.
  typedef struct packed {
    logic            payload_valid;
    logic [7:0]      payload_byte;
    logic            header_ready;
    logic [7:0]      stream_kind;
    logic [15:0]     declared_length;
    logic [1:0]      scrambling;
    logic [3:0]      header_flags;
    logic [TS_W-1:0] presentation_time;
    logic [TS_W-1:0] decode_time;
    logic            packet_done;
    err_e            error_code;
  } res_t;

endpackage

>>> hw/rtl/pes_header_parser_top.sv
// Top level of the PES packet header parser: handshake and result register.
// Depends on pes_hp_pkg and pes_hp_core.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one PES byte per
//    transfer plus packet_start_i, set on byte 0 of each packet.
//  - Output channel (out_valid_o / out_ready_i) carries exactly one result
//    per input transfer, in order: payload byte with its valid flag, the
//    captured header fields, decoded PTS/DTS, header_ready and packet_done
//    pulses, and the latched error code.
//  - Latency: the result of a byte is valid the cycle after its transfer.
//  - Throughput: one byte per cycle unless the receiver stalls. The only
//    storage between the sides is the result register, so in_ready_o is
//    high whenever that register is empty or being drained in the same cycle.
//  - Receiver stall: the result register holds, in_ready_o drops, and the
//    parser state freezes until the result is taken.
//  - Reset: parser goes idle, captured fields and timestamps read as zero,
//    and bytes are ignored (still answered) until a start mark arrives.
//  - Errors hold, with no payload passed, until the next start mark.
module pes_header_parser_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        packet_start_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        payload_valid_o,
  output logic [7:0]                  payload_byte_o,
  output logic                        header_ready_o,
  output logic [7:0]                  stream_kind_o,
  output logic [15:0]                 declared_length_o,
  output logic [1:0]                  scrambling_o,
  output logic [3:0]                  header_flags_o,
  output logic [pes_hp_pkg::TS_W-1:0] presentation_time_o,
  output logic [pes_hp_pkg::TS_W-1:0] decode_time_o,
  output logic                        packet_done_o,
  output logic [2:0]                  error_code_o
);
  import pes_hp_pkg::*;

  logic in_xfer;
  logic out_valid_q;
  res_t res_d, res_q;

  // Accept whenever the result slot is free or drains this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  pes_hp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_xfer),
    .data_byte_i    (data_byte_i),
    .packet_start_i (packet_start_i),
    .res_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: no reset needed, qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_xfer) res_q <= res_d;
  end

  assign out_valid_o         = out_valid_q;
  assign payload_valid_o     = res_q.payload_valid;
  assign payload_byte_o      = res_q.payload_byte;
  assign header_ready_o      = res_q.header_ready;
  assign stream_kind_o       = res_q.stream_kind;
  assign declared_length_o   = res_q.declared_length;
  assign scrambling_o        = res_q.scrambling;
  assign header_flags_o      = res_q.header_flags;
  assign presentation_time_o = res_q.presentation_time;
  assign decode_time_o       = res_q.decode_time;
  assign packet_done_o       = res_q.packet_done;
  assign error_code_o        = res_q.error_code;

  // Every input transfer leaves a result pending in the next cycle.
  a_xfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("input transfer without a result");

  // An empty result slot never blocks the input side.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // Payload only flows from a clean packet.
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (error_code_o == ERR_NONE))
    else $error("payload passed while an error is latched");

  // The header-complete byte is never itself a payload byte.
  a_hr_not_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(header_ready_o && payload_valid_o))
    else $error("header_ready and payload_valid together");

endmodule

>>> hw/rtl/pes_hp_core.sv
// Parser state and per-byte next-state logic for the PES header parser.
// Depends on pes_hp_pkg. State advances only on an input transfer.
module pes_hp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              packet_start_i,
  output pes_hp_pkg::res_t  res_o
);
  import pes_hp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FIXED, PH_OPT, PH_STAMPS, PH_PAYLOAD, PH_HALT
  } phase_e;

  localparam logic [1:0] FLG_PTS     = 2'b10;
  localparam logic [1:0] FLG_PTS_DTS = 2'b11;
  localparam logic [3:0] PFX_PTS     = 4'b0010;
  localparam logic [3:0] PFX_PTS_ONLY_DTS = 4'b0011;
  localparam logic [3:0] PFX_DTS     = 4'b0001;

  // Number of timestamp bytes implied by the PTS_DTS flags.
  function automatic logic [3:0] stamp_bytes(input logic [1:0] f);
    unique case (f)
      FLG_PTS:     stamp_bytes = 4'd5;
      FLG_PTS_DTS: stamp_bytes = 4'd10;
      default:     stamp_bytes = 4'd0;
    endcase
  endfunction

  phase_e          phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]      sid_q, sid_d;
  logic [15:0]     len_q, len_d;
  logic [7:0]      opt_q, opt_d;
  logic [7:0]      hdl_q, hdl_d;
  logic [TS_W-1:0] acc_q, acc_d;
  logic [TS_W-1:0] pts_q, pts_d;
  logic [TS_W-1:0] dts_q, dts_d;
  err_e            err_q, err_d;

  logic             pv, hr, pd;
  logic [7:0]       pb;

  always_comb begin
    phase_e           cur;
    logic             active;
    logic             abort;
    logic [1:0]       f;
    logic [3:0]       need;
    logic [POS_W-1:0] off;
    logic [3:0]       off_lo;
    logic [2:0]       k;
    logic             second;
    logic [3:0]       want;

    phase_d = phase_q;
    pos_d   = pos_q;
    sid_d   = sid_q;
    len_d   = len_q;
    opt_d   = opt_q;
    hdl_d   = hdl_q;
    acc_d   = acc_q;
    pts_d   = pts_q;
    dts_d   = dts_q;
    err_d   = err_q;
    pv = 1'b0;
    pb = 8'd0;
    hr = 1'b0;
    pd = 1'b0;
    abort  = 1'b0;
    f      = 2'b00;
    need   = 4'd0;
    off    = '0;
    off_lo = 4'd0;
    k      = 3'd0;
    second = 1'b0;
    want   = 4'd0;

    // A start mark abandons whatever was in progress.
    if (packet_start_i) begin
      phase_d = PH_FIXED;
      pos_d   = '0;
      sid_d   = '0;
      len_d   = '0;
      opt_d   = '0;
      hdl_d   = '0;
      acc_d   = '0;
      pts_d   = '0;
      dts_d   = '0;
      err_d   = ERR_NONE;
    end
    cur    = phase_d;
    active = (cur != PH_IDLE) && (cur != PH_HALT);

    unique case (cur)
      PH_FIXED: begin
        if (pos_d < POS_W'(3)) begin
          want = 4'd0;
          if (data_byte_i != ((pos_d == POS_W'(2)) ? 8'd1 : 8'd0)) begin
            err_d   = ERR_START;
            phase_d = PH_HALT;
          end
        end else if (pos_d == POS_W'(3)) begin
          sid_d = data_byte_i;
        end else if (pos_d == POS_W'(4)) begin
          len_d = {data_byte_i, 8'd0};
        end else begin
          len_d = {len_d[15:8], data_byte_i};
          // audio 110x_xxxx or video 1110_xxxx carry the optional header
          if ((sid_d[7:5] == 3'b110) || (sid_d[7:4] == 4'b1110)) begin
            phase_d = PH_OPT;
          end else begin
            hr      = 1'b1;
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_OPT: begin
        if (pos_d == POS_W'(6)) begin
          opt_d[5:0] = data_byte_i[5:0];
        end else if (pos_d == POS_W'(7)) begin
          opt_d[7:6] = data_byte_i[7:6];
        end else begin
          f     = opt_d[7:6];
          need  = stamp_bytes(f);
          hdl_d = data_byte_i;
          if (hdl_d == 8'd0) begin
            if (f[1]) begin
              err_d   = ERR_SHORT;
              phase_d = PH_HALT;
            end else begin
              hr      = 1'b1;
              phase_d = PH_PAYLOAD;
            end
          end else if (!f[1]) begin
            err_d   = ERR_NO_PTS;
            phase_d = PH_HALT;
          end else if (hdl_d < 8'(need)) begin
            err_d   = ERR_SHORT;
            phase_d = PH_HALT;
          end else begin
            phase_d = PH_STAMPS;
          end
        end
      end
      PH_STAMPS: begin
        f    = opt_d[7:6];
        need = stamp_bytes(f);
        off  = pos_d - POS_W'(9);
        if (off < POS_W'(need)) begin
          off_lo = off[3:0];
          second = (off_lo >= 4'd5);
          k      = second ? 3'(off_lo - 4'd5) : off_lo[2:0];
          unique case (k)
            3'd0: begin
              want = second ? PFX_DTS : ((f == FLG_PTS_DTS) ? PFX_PTS_ONLY_DTS : PFX_PTS);
              if (data_byte_i[7:4] != want) begin
                err_d   = ERR_PREFIX;
                phase_d = PH_HALT;
                abort   = 1'b1;
              end else begin
                acc_d = {data_byte_i[3:1], 30'd0};
              end
            end
            3'd1: acc_d = acc_d | {3'd0, data_byte_i, 22'd0};
            3'd2: acc_d = acc_d | {11'd0, data_byte_i[7:1], 15'd0};
            3'd3: acc_d = acc_d | {18'd0, data_byte_i, 7'd0};
            default: acc_d = acc_d | {26'd0, data_byte_i[7:1]};
          endcase
          // marker bits close the 3-, 15- and 15-bit groups
          if (!abort && (k != 3'd1) && (k != 3'd3) && !data_byte_i[0]) begin
            err_d   = ERR_MARKER;
            phase_d = PH_HALT;
            abort   = 1'b1;
          end
          if (!abort && (k == 3'd4)) begin
            if (!second) begin
              pts_d = acc_d;
              if (f == FLG_PTS) dts_d = acc_d;
            end else begin
              dts_d = acc_d;
            end
          end
        end
        if (!abort && ((off + POS_W'(1)) == POS_W'(hdl_d))) begin
          hr      = 1'b1;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pv = 1'b1;
        pb = data_byte_i;
      end
      default: ;
    endcase

    // Completion against the declared length, counted after the fixed six bytes.
    if (active && (err_d == ERR_NONE)) begin
      if ((pos_d >= POS_W'(6)) && (len_d != 16'd0) &&
          ((pos_d - POS_W'(5)) == POS_W'(len_d))) begin
        pd      = 1'b1;
        phase_d = PH_HALT;
      end
      if (pos_d != {POS_W{1'b1}}) pos_d = pos_d + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      sid_q   <= '0;
      len_q   <= '0;
      opt_q   <= '0;
      hdl_q   <= '0;
      acc_q   <= '0;
      pts_q   <= '0;
      dts_q   <= '0;
      err_q   <= ERR_NONE;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sid_q   <= sid_d;
      len_q   <= len_d;
      opt_q   <= opt_d;
      hdl_q   <= hdl_d;
      acc_q   <= acc_d;
      pts_q   <= pts_d;
      dts_q   <= dts_d;
      err_q   <= err_d;
    end
  end

  always_comb begin
    res_o.payload_valid     = pv;
    res_o.payload_byte      = pb;
    res_o.header_ready      = hr;
    res_o.stream_kind       = sid_d;
    res_o.declared_length   = len_d;
    res_o.scrambling        = opt_d[5:4];
    res_o.header_flags      = opt_d[3:0];
    res_o.presentation_time = pts_d;
    res_o.decode_time       = dts_d;
    res_o.packet_done       = pd;
    res_o.error_code        = err_d;
  end

endmodule
